// ===== rtl/iibs_pkg.sv =====
// Shared constants, register indexes and controller/datapath bundles for the
// integral image box sum core. No dependencies.
package iibs_pkg;

	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;

	localparam int PIX_W     = 8;
	localparam int DIM_W     = 9;
	localparam int SUM_W     = 24;
	localparam int SQ_W      = 32;
	localparam int RSUM_W    = 16;
	localparam int RSQ_W     = 24;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

	localparam logic [1:0] CORNER_A = 2'd0;
	localparam logic [1:0] CORNER_B = 2'd1;
	localparam logic [1:0] CORNER_C = 2'd2;
	localparam logic [1:0] CORNER_D = 2'd3;

	typedef struct packed {
		logic       take_load;
		logic       take_query;
		logic       clear;
		logic       ld_rd;
		logic       ld_wr;
		logic       q_rd;
		logic [1:0] corner;
		logic       out_load;
	} iibs_cmd_t;

	typedef struct packed {
		logic range_bad;
		logic clear_last;
		logic out_busy;
	} iibs_stat_t;

endpackage

// ===== rtl/iibs_if.sv =====
// Handshake channels of the integral image box sum core: item, result and
// register write words. Depends on iibs_pkg.
interface iibs_req_if;
	logic                        valid;
	logic                        ready;
	logic                        mode;
	logic [iibs_pkg::PIX_W-1:0]  pixel;
	logic [iibs_pkg::DIM_W-1:0]  box_x;
	logic [iibs_pkg::DIM_W-1:0]  box_y;
	logic [iibs_pkg::DIM_W-1:0]  box_w;
	logic [iibs_pkg::DIM_W-1:0]  box_h;

	modport source (output valid, mode, pixel, box_x, box_y, box_w, box_h, input ready);
	modport sink   (input valid, mode, pixel, box_x, box_y, box_w, box_h, output ready);
endinterface

interface iibs_rsp_if;
	logic                       valid;
	logic                       ready;
	logic [iibs_pkg::SUM_W-1:0] box_sum;
	logic [iibs_pkg::SQ_W-1:0]  box_sum_sq;
	logic                       range_error;

	modport source (output valid, box_sum, box_sum_sq, range_error, input ready);
	modport sink   (input valid, box_sum, box_sum_sq, range_error, output ready);
endinterface

interface iibs_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [iibs_pkg::CFG_IDX_W-1:0] index;
	logic [iibs_pkg::DIM_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/iibs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module iibs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/iibs_ctrl.sv =====
// Controller state machine: clearing pass, pixel load and box query sequencing.
// Depends on iibs_pkg.
module iibs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	input  logic                req_mode,
	output logic                req_ready,
	input  iibs_pkg::iibs_stat_t stat,
	output iibs_pkg::iibs_cmd_t  cmd
);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_LD_RD = 3'd2;
	localparam logic [2:0] S_LD_WR = 3'd3;
	localparam logic [2:0] S_Q_RD  = 3'd4;
	localparam logic [2:0] S_Q_FIN = 3'd5;
	localparam logic [2:0] S_Q_OUT = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic [1:0] cnt_q;
	logic       take;

	assign req_ready = (state_q == S_IDLE);
	assign take      = req_valid & req_ready;

	always_comb begin
		cmd            = '0;
		state_d        = state_q;
		cmd.corner     = cnt_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (stat.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (take) begin
					if (!req_mode) begin
						cmd.take_load = 1'b1;
						state_d       = S_LD_RD;
					end else begin
						cmd.take_query = 1'b1;
						state_d        = stat.range_bad ? S_Q_OUT : S_Q_RD;
					end
				end
			end
			S_LD_RD: begin
				cmd.ld_rd = 1'b1;
				state_d   = S_LD_WR;
			end
			S_LD_WR: begin
				cmd.ld_wr = 1'b1;
				state_d   = S_IDLE;
			end
			S_Q_RD: begin
				cmd.q_rd = 1'b1;
				if (cnt_q == iibs_pkg::CORNER_D) begin
					state_d = S_Q_FIN;
				end
			end
			S_Q_FIN: begin
				state_d = S_Q_OUT;
			end
			S_Q_OUT: begin
				if (!stat.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q   <= iibs_pkg::CORNER_A;
		end else begin
			state_q <= state_d;
			if (cmd.take_query) begin
				cnt_q <= iibs_pkg::CORNER_A;
			end else if (cmd.q_rd) begin
				cnt_q <= cnt_q + 2'd1;
			end
		end
	end

endmodule

// ===== rtl/iibs_dp.sv =====
// Datapath: size registers, load position and row sums, both table RAMs,
// corner accumulation and the result register. Depends on iibs_pkg, iibs_ram.
module iibs_dp #(
	parameter int MAX_WIDTH  = iibs_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = iibs_pkg::MAX_HEIGHT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  iibs_pkg::iibs_cmd_t            cmd,
	output iibs_pkg::iibs_stat_t           stat,
	input  logic                           cfg_we,
	input  logic [iibs_pkg::CFG_IDX_W-1:0] cfg_idx,
	input  logic [iibs_pkg::DIM_W-1:0]     cfg_data,
	input  logic [iibs_pkg::PIX_W-1:0]     pixel,
	input  logic [iibs_pkg::DIM_W-1:0]     box_x,
	input  logic [iibs_pkg::DIM_W-1:0]     box_y,
	input  logic [iibs_pkg::DIM_W-1:0]     box_w,
	input  logic [iibs_pkg::DIM_W-1:0]     box_h,
	input  logic                           out_ready,
	output logic                           out_valid,
	output logic [iibs_pkg::SUM_W-1:0]     box_sum,
	output logic [iibs_pkg::SQ_W-1:0]      box_sum_sq,
	output logic                           range_error
);

	localparam int CW     = $clog2(MAX_WIDTH + 1);
	localparam int RW     = $clog2(MAX_HEIGHT + 1);
	localparam int STRIDE = MAX_WIDTH + 1;
	localparam int DEPTH  = (MAX_WIDTH + 1) * (MAX_HEIGHT + 1);
	localparam int AW     = $clog2(DEPTH);
	localparam int EW0    = (CW > RW) ? CW : RW;
	localparam int EW     = (EW0 > iibs_pkg::DIM_W + 1) ? EW0 : iibs_pkg::DIM_W + 1;
	localparam int SUM_W  = iibs_pkg::SUM_W;
	localparam int SQ_W   = iibs_pkg::SQ_W;
	localparam int RSUM_W = iibs_pkg::RSUM_W;
	localparam int RSQ_W  = iibs_pkg::RSQ_W;

	function automatic logic [AW-1:0] tbl_addr(input logic [RW-1:0] r, input logic [CW-1:0] c);
		return AW'(r) * AW'(STRIDE) + AW'(c);
	endfunction

	logic [iibs_pkg::DIM_W-1:0] img_w_q;
	logic [iibs_pkg::DIM_W-1:0] img_h_q;
	logic [EW-1:0]              w_eff;
	logic [EW-1:0]              h_eff;

	logic [CW-1:0]     col_q;
	logic [RW-1:0]     row_q;
	logic [RSUM_W-1:0] rs_q;
	logic [RSQ_W-1:0]  rq_q;
	logic              wrap_col;
	logic [RW-1:0]     row_t;
	logic [15:0]       psq;

	logic [CW-1:0] qx_q;
	logic [CW-1:0] qx2_q;
	logic [RW-1:0] qy_q;
	logic [RW-1:0] qy2_q;
	logic          err_q;
	logic [iibs_pkg::DIM_W:0] x2;
	logic [iibs_pkg::DIM_W:0] y2;

	logic [AW-1:0] clr_q;
	logic [AW-1:0] waddr;
	logic [AW-1:0] raddr;
	logic [AW-1:0] up_addr;
	logic [AW-1:0] at_addr;
	logic [AW-1:0] corner_addr;
	logic          we;
	logic [SUM_W-1:0] sum_wd;
	logic [SQ_W-1:0]  sq_wd;
	logic [SUM_W-1:0] rd_sum;
	logic [SQ_W-1:0]  rd_sq;

	logic             rd_valid_s1;
	logic [1:0]       rd_corner_s1;
	logic [SUM_W-1:0] acc_sum_q;
	logic [SQ_W-1:0]  acc_sq_q;
	logic             out_valid_q;

	always_comb begin
		if (img_w_q == '0) begin
			w_eff = EW'(1);
		end else if (EW'(img_w_q) > EW'(MAX_WIDTH)) begin
			w_eff = EW'(MAX_WIDTH);
		end else begin
			w_eff = EW'(img_w_q);
		end
		if (img_h_q == '0) begin
			h_eff = EW'(1);
		end else if (EW'(img_h_q) > EW'(MAX_HEIGHT)) begin
			h_eff = EW'(MAX_HEIGHT);
		end else begin
			h_eff = EW'(img_h_q);
		end
	end

	assign x2 = {1'b0, box_x} + {1'b0, box_w};
	assign y2 = {1'b0, box_y} + {1'b0, box_h};

	assign stat.range_bad  = (EW'(x2) > w_eff) || (EW'(y2) > h_eff);
	assign stat.clear_last = (clr_q == AW'(DEPTH - 1));
	assign stat.out_busy   = out_valid_q & ~out_ready;

	assign wrap_col = (EW'(col_q) >= w_eff);
	assign row_t    = wrap_col ? row_q + RW'(1) : row_q;
	assign psq      = 16'(pixel) * 16'(pixel);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			img_w_q <= iibs_pkg::DIM_W'(256);
			img_h_q <= iibs_pkg::DIM_W'(256);
		end else if (cfg_we) begin
			unique case (cfg_idx)
				iibs_pkg::REG_IMAGE_WIDTH:  img_w_q <= cfg_data;
				iibs_pkg::REG_IMAGE_HEIGHT: img_h_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			rs_q  <= '0;
			rq_q  <= '0;
		end else if (cmd.take_load) begin
			col_q <= wrap_col ? '0 : col_q;
			row_q <= (EW'(row_t) >= h_eff) ? '0 : row_t;
			rs_q  <= (wrap_col ? '0 : rs_q) + RSUM_W'(pixel);
			rq_q  <= (wrap_col ? '0 : rq_q) + RSQ_W'(psq);
		end else if (cmd.ld_wr) begin
			col_q <= col_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_query) begin
			qx_q  <= CW'(box_x);
			qx2_q <= CW'(x2);
			qy_q  <= RW'(box_y);
			qy2_q <= RW'(y2);
			err_q <= stat.range_bad;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	always_comb begin
		unique case (cmd.corner)
			iibs_pkg::CORNER_A: corner_addr = tbl_addr(qy_q, qx_q);
			iibs_pkg::CORNER_B: corner_addr = tbl_addr(qy2_q, qx2_q);
			iibs_pkg::CORNER_C: corner_addr = tbl_addr(qy2_q, qx_q);
			iibs_pkg::CORNER_D: corner_addr = tbl_addr(qy_q, qx2_q);
		endcase
	end

	assign up_addr = tbl_addr(row_q, col_q + CW'(1));
	assign at_addr = tbl_addr(row_q + RW'(1), col_q + CW'(1));
	assign raddr   = cmd.ld_rd ? up_addr : corner_addr;
	assign we      = cmd.clear | cmd.ld_wr;
	assign waddr   = cmd.clear ? clr_q : at_addr;
	assign sum_wd  = cmd.clear ? '0 : rd_sum + SUM_W'(rs_q);
	assign sq_wd   = cmd.clear ? '0 : rd_sq + SQ_W'(rq_q);

	iibs_ram #(
		.WIDTH (SUM_W),
		.DEPTH (DEPTH)
	) u_sum_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (sum_wd),
		.raddr (raddr),
		.rdata (rd_sum)
	);

	iibs_ram #(
		.WIDTH (SQ_W),
		.DEPTH (DEPTH)
	) u_sq_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (sq_wd),
		.raddr (raddr),
		.rdata (rd_sq)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_valid_s1 <= 1'b0;
		end else begin
			rd_valid_s1 <= cmd.q_rd;
		end
	end

	always_ff @(posedge clk) begin
		rd_corner_s1 <= cmd.corner;
		if (cmd.take_query) begin
			acc_sum_q <= '0;
			acc_sq_q  <= '0;
		end else if (rd_valid_s1) begin
			if (rd_corner_s1 == iibs_pkg::CORNER_C || rd_corner_s1 == iibs_pkg::CORNER_D) begin
				acc_sum_q <= acc_sum_q - rd_sum;
				acc_sq_q  <= acc_sq_q - rd_sq;
			end else begin
				acc_sum_q <= acc_sum_q + rd_sum;
				acc_sq_q  <= acc_sq_q + rd_sq;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			box_sum     <= err_q ? '0 : acc_sum_q;
			box_sum_sq  <= err_q ? '0 : acc_sq_q;
			range_error <= err_q;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/integral_image_box_sum_core.sv =====
// Channel  Dir  Word
// req      in   mode, pixel, box_x, box_y, box_w, box_h
// rsp      out  box_sum, box_sum_sq, range_error
// cfg      in   index (0 image_width, 1 image_height), data
//
// A pixel load is an accept, a read of the entry above and a write of the new entry.
// A query makes the four corner reads through each table's single read port, then
// the final add and the result load; an out-of-range query goes straight to the load.
// After reset a clearing pass zeroes all (MAX_WIDTH+1)*(MAX_HEIGHT+1) entries (66049 by
// default) of both tables; req.ready stays low meanwhile, cfg writes are taken.
// A held result stalls only the next query, in its result-load state; loads proceed.
// Depends on iibs_pkg, iibs_if, iibs_ctrl, iibs_dp.
module integral_image_box_sum_core #(
	parameter int MAX_WIDTH  = iibs_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = iibs_pkg::MAX_HEIGHT_DEF
) (
	input logic          clk,
	input logic          arst_n,
	iibs_req_if.sink     req,
	iibs_rsp_if.source   rsp,
	iibs_cfg_if.sink     cfg
);

	iibs_pkg::iibs_cmd_t  cmd;
	iibs_pkg::iibs_stat_t stat;

	assign cfg.ready = 1'b1;

	iibs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_mode  (req.mode),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	iibs_dp #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.cfg_we      (cfg.valid & cfg.ready),
		.cfg_idx     (cfg.index),
		.cfg_data    (cfg.data),
		.pixel       (req.pixel),
		.box_x       (req.box_x),
		.box_y       (req.box_y),
		.box_w       (req.box_w),
		.box_h       (req.box_h),
		.out_ready   (rsp.ready),
		.out_valid   (rsp.valid),
		.box_sum     (rsp.box_sum),
		.box_sum_sq  (rsp.box_sum_sq),
		.range_error (rsp.range_error)
	);

endmodule
